/* src/stdp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdp_pkg: shared types and constants
// Sizes, action codes, register indexes and the structs passed between the
// STDP update stages.
// ----------------------------------------------------------------------------
package stdp_pkg;

    localparam int WINDOW_BINS  = 1024;
    localparam int PRE_NEURONS  = 1024;
    localparam int POST_NEURONS = 1024;

    // fixed field widths
    localparam int NEURON_W = 10;
    localparam int SLOT_W   = 10;
    localparam int WEIGHT_W = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;

    localparam int BIN_W = $clog2(WINDOW_BINS);

    // only indices reachable through a 10-bit field need storage
    localparam int PRE_DEPTH  = (PRE_NEURONS < (2 ** NEURON_W)) ? PRE_NEURONS : (2 ** NEURON_W);
    localparam int POST_DEPTH = (POST_NEURONS < (2 ** NEURON_W)) ? POST_NEURONS : (2 ** NEURON_W);
    localparam int PRE_AW     = (PRE_DEPTH > 1) ? $clog2(PRE_DEPTH) : 1;
    localparam int POST_AW    = (POST_DEPTH > 1) ? $clog2(POST_DEPTH) : 1;
    localparam int CLR_DEPTH  = (PRE_DEPTH > POST_DEPTH) ? PRE_DEPTH : POST_DEPTH;
    localparam int CLR_W      = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_ENABLE     = 2'd0;
    localparam logic [1:0] REG_MIN_WEIGHT = 2'd1;
    localparam logic [1:0] REG_MAX_WEIGHT = 2'd2;

    localparam logic TABLE_POTENTIATION = 1'b0;
    localparam logic TABLE_DEPRESSION   = 1'b1;

    typedef enum logic [1:0] {
        ACT_PRE       = 2'd0,
        ACT_POST      = 2'd1,
        ACT_REC_POST  = 2'd2,
        ACT_WIN_WRITE = 2'd3
    } action_t;

    typedef logic signed [WEIGHT_W-1:0] weight_t;

    // spike time store: write and read request at acceptance
    typedef struct packed {
        logic                accept;
        logic                pre_wr;
        logic                post_wr;
        logic [PRE_AW-1:0]   pre_addr;
        logic [POST_AW-1:0]  post_addr;
        logic [TIME_W-1:0]   now;
    } time_req_t;

    typedef struct packed {
        logic                pre_spiked;
        logic [TIME_W-1:0]   pre_time;
        logic                post_spiked;
        logic [TIME_W-1:0]   post_time;
    } time_rd_t;

    typedef struct packed {
        logic                wr;
        logic                sel;
        logic [BIN_W-1:0]    slot;
        weight_t             value;
    } win_wr_t;

    typedef struct packed {
        logic                valid;
        logic                depress;
        logic                spiked;
        logic [TIME_W-1:0]   last;
        logic [TIME_W-1:0]   now;
    } lookup_t;

    typedef struct packed {
        weight_t             weight;
        logic [NEURON_W-1:0] target;
        logic                transmit;
    } result_t;

endpackage

/* src/stdp_spike_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdp_spike_mem: last spike time stores
// Pre and post time memories with a spiked flag per word, cleared by a sweep
// after reset. Read data registered at acceptance.
// ----------------------------------------------------------------------------
module stdp_spike_mem
    import stdp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  time_req_t req,
    output time_rd_t  rd,
    output logic      busy
);

    // word = {spiked, time}
    logic [TIME_W:0] pre_mem  [PRE_DEPTH];
    logic [TIME_W:0] post_mem [POST_DEPTH];
    logic [TIME_W:0] pre_rd_reg;
    logic [TIME_W:0] post_rd_reg;

    logic             clr_active_reg, clr_active_next;
    logic [CLR_W-1:0] clr_idx_reg, clr_idx_next;

    logic               pre_we, post_we;
    logic [PRE_AW-1:0]  pre_waddr;
    logic [POST_AW-1:0] post_waddr;
    logic [TIME_W:0]    pre_wdata, post_wdata;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == CLR_W'(CLR_DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
        end
    end

    always_comb
    begin
        if (clr_active_reg)
        begin
            pre_we     = 32'(clr_idx_reg) < PRE_DEPTH;
            post_we    = 32'(clr_idx_reg) < POST_DEPTH;
            pre_waddr  = PRE_AW'(clr_idx_reg);
            post_waddr = POST_AW'(clr_idx_reg);
            pre_wdata  = '0;
            post_wdata = '0;
        end
        else
        begin
            pre_we     = req.pre_wr;
            post_we    = req.post_wr;
            pre_waddr  = req.pre_addr;
            post_waddr = req.post_addr;
            pre_wdata  = {1'b1, req.now};
            post_wdata = {1'b1, req.now};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pre_we)
        begin
            pre_mem[pre_waddr] <= pre_wdata;
        end
        if (req.accept)
        begin
            pre_rd_reg <= pre_mem[req.pre_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (post_we)
        begin
            post_mem[post_waddr] <= post_wdata;
        end
        if (req.accept)
        begin
            post_rd_reg <= post_mem[req.post_addr];
        end
    end

    assign rd.pre_spiked  = pre_rd_reg[TIME_W];
    assign rd.pre_time    = pre_rd_reg[TIME_W-1:0];
    assign rd.post_spiked = post_rd_reg[TIME_W];
    assign rd.post_time   = post_rd_reg[TIME_W-1:0];
    assign busy           = clr_active_reg;

endmodule

/* src/stdp_window_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdp_window_mem: STDP window tables
// Delay bin from the spike times, then a registered read of the selected
// window table. Table writes come straight from accepted words.
// ----------------------------------------------------------------------------
module stdp_window_mem
    import stdp_pkg::*;
(
    input  logic    clk,
    input  win_wr_t wr,
    input  lookup_t lk,
    output weight_t win_value
);

    weight_t pot_mem [WINDOW_BINS];
    weight_t dep_mem [WINDOW_BINS];
    weight_t pot_rd_reg, dep_rd_reg;
    logic    depress_reg;

    logic [TIME_W-1:0] delta;
    logic [BIN_W-1:0]  bin;

    // delay wraps modulo 2^32; never spiked or far delays hit the last bin
    always_comb
    begin
        delta = lk.now - lk.last;
        if (!lk.spiked || (delta >= TIME_W'(WINDOW_BINS - 1)))
        begin
            bin = BIN_W'(WINDOW_BINS - 1);
        end
        else
        begin
            bin = delta[BIN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr && (wr.sel == TABLE_POTENTIATION))
        begin
            pot_mem[wr.slot] <= wr.value;
        end
        if (lk.valid)
        begin
            pot_rd_reg <= pot_mem[bin];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr && (wr.sel == TABLE_DEPRESSION))
        begin
            dep_mem[wr.slot] <= wr.value;
        end
        if (lk.valid)
        begin
            dep_rd_reg  <= dep_mem[bin];
            depress_reg <= lk.depress;
        end
    end

    assign win_value = depress_reg ? dep_rd_reg : pot_rd_reg;

endmodule

/* src/stdp_weight_clip.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdp_weight_clip: weight add and clip
// Pre events clip to both bounds, post events to the top bound and the
// format floor; with enable low the weight passes through.
// ----------------------------------------------------------------------------
module stdp_weight_clip
    import stdp_pkg::*;
(
    input  logic    enable,
    input  logic    depress,
    input  weight_t weight_in,
    input  weight_t win_value,
    input  weight_t min_weight,
    input  weight_t max_weight,
    output weight_t weight_out
);

    // most negative Q2.14 value at the sum width
    localparam logic signed [WEIGHT_W:0] SUM_FLOOR = {2'b11, {(WEIGHT_W - 1){1'b0}}};

    logic signed [WEIGHT_W:0] sum;
    logic signed [WEIGHT_W:0] lo;
    logic signed [WEIGHT_W:0] hi;

    always_comb
    begin
        sum = {weight_in[WEIGHT_W-1], weight_in} + {win_value[WEIGHT_W-1], win_value};
        lo  = {min_weight[WEIGHT_W-1], min_weight};
        hi  = {max_weight[WEIGHT_W-1], max_weight};

        if (!enable)
        begin
            weight_out = weight_in;
        end
        else if (depress)
        begin
            // lower bound is tested first: when the bounds cross, sums below it take min_weight, all others max_weight
            priority if (sum < lo)
            begin
                weight_out = min_weight;
            end
            else if (sum > hi)
            begin
                weight_out = max_weight;
            end
            else
            begin
                weight_out = sum[WEIGHT_W-1:0];
            end
        end
        else
        begin
            priority if (sum > hi)
            begin
                weight_out = max_weight;
            end
            else if (sum < SUM_FLOOR)
            begin
                weight_out = SUM_FLOOR[WEIGHT_W-1:0];
            end
            else
            begin
                weight_out = sum[WEIGHT_W-1:0];
            end
        end
    end

endmodule

/* src/stdp_out_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdp_out_fifo: result queue
// Small queue between the update pipeline and the output channel.
// ----------------------------------------------------------------------------
module stdp_out_fifo
    import stdp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  result_t            push_data,
    input  logic               pop,
    output result_t            head,
    output logic [FIFO_CW-1:0] count
);

    result_t fifo_mem [FIFO_DEPTH];

    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = fifo_mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

/* src/pair_stdp_weight_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pair_stdp_weight_update: pair-based STDP weight update
// Keeps last spike times and two window tables; pre and post synapse words
// give the updated weight.
// ----------------------------------------------------------------------------
// One input word is taken per clock while in_stall is low. A pre or post
// synapse word gives its result word through the spike time memory read,
// then the delay bin and the window memory read, then the add, clip and
// write into a four-word result queue. Record and window-write words give
// no result. Outside the clear sweep, in_stall rises only when the queue
// plus the words still in flight could overflow it, so with out_stall low
// the block runs at a full word per cycle. After reset the spiked flags in
// the time memories are swept clear, one entry per cycle, across the larger
// neuron store; in_stall is high for that time while register writes
// are taken as usual. Register map: 0x0 plasticity_enable,
// 0x4 min_weight, 0x8 max_weight (signed Q2.14, read back sign-extended).
// ----------------------------------------------------------------------------
module pair_stdp_weight_update
    import stdp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic [NEURON_W-1:0] pre_neuron,
    input  logic [NEURON_W-1:0] post_neuron,
    input  weight_t             weight_in,
    input  logic [TIME_W-1:0]   now_time,
    input  logic                table_select,
    input  logic [SLOT_W-1:0]   window_slot,
    input  weight_t             window_value,

    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output weight_t             weight_out,
    output logic [NEURON_W-1:0] target_neuron,
    output logic                transmit,

    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [CFG_DW-1:0]   pwdata,
    output logic [CFG_DW-1:0]   prdata,
    output logic                pready
);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic    enable_reg;
    weight_t min_weight_reg;
    weight_t max_weight_reg;
    logic    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            min_weight_reg <= '0;
            max_weight_reg <= weight_t'(16'sh4000);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ENABLE:     enable_reg     <= pwdata[0];
                REG_MIN_WEIGHT: min_weight_reg <= pwdata[WEIGHT_W-1:0];
                REG_MAX_WEIGHT: max_weight_reg <= pwdata[WEIGHT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ENABLE:     prdata = {{(CFG_DW - 1){1'b0}}, enable_reg};
            REG_MIN_WEIGHT: prdata = {{(CFG_DW - WEIGHT_W){min_weight_reg[WEIGHT_W-1]}},
                                      min_weight_reg};
            REG_MAX_WEIGHT: prdata = {{(CFG_DW - WEIGHT_W){max_weight_reg[WEIGHT_W-1]}},
                                      max_weight_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // acceptance stage
    // ------------------------------------------------------------------
    action_t   act_in;
    logic      accept;
    logic      pre_ok, post_ok;
    time_req_t time_req;
    time_rd_t  time_rd;
    win_wr_t   win_wr;
    logic      clr_busy;

    assign act_in  = action_t'(action);
    assign accept  = in_valid && !in_stall;
    // indices beyond the neuron count never spike and never record
    assign pre_ok  = 32'(pre_neuron) < PRE_NEURONS;
    assign post_ok = 32'(post_neuron) < POST_NEURONS;

    always_comb
    begin
        time_req.accept    = accept;
        time_req.pre_wr    = accept && (act_in == ACT_PRE) && pre_ok;
        time_req.post_wr   = accept && (act_in == ACT_REC_POST) && enable_reg && post_ok;
        time_req.pre_addr  = PRE_AW'(pre_neuron);
        time_req.post_addr = POST_AW'(post_neuron);
        time_req.now       = now_time;

        // out-of-range slots are dropped
        win_wr.wr    = accept && (act_in == ACT_WIN_WRITE) && (32'(window_slot) < WINDOW_BINS);
        win_wr.sel   = table_select;
        win_wr.slot  = BIN_W'(window_slot);
        win_wr.value = window_value;
    end

    stdp_spike_mem u_spike_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (time_req),
        .rd    (time_rd),
        .busy  (clr_busy)
    );

    // ------------------------------------------------------------------
    // stage 1: delay bin and window read
    // ------------------------------------------------------------------
    logic                s1_valid_reg;
    action_t             s1_action_reg;
    weight_t             s1_weight_reg;
    logic [NEURON_W-1:0] s1_post_reg;
    logic [TIME_W-1:0]   s1_now_reg;
    logic                s1_pre_ok_reg;
    logic                s1_post_ok_reg;
    lookup_t             lookup;
    logic                s1_is_pre;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg  <= act_in;
            s1_weight_reg  <= weight_in;
            s1_post_reg    <= post_neuron;
            s1_now_reg     <= now_time;
            s1_pre_ok_reg  <= pre_ok;
            s1_post_ok_reg <= post_ok;
        end
    end

    // pre events look back at the post neuron, post events at the pre neuron
    assign s1_is_pre = s1_action_reg == ACT_PRE;

    always_comb
    begin
        lookup.valid   = s1_valid_reg && ((s1_action_reg == ACT_PRE) ||
                                          (s1_action_reg == ACT_POST));
        lookup.depress = s1_is_pre;
        lookup.spiked  = s1_is_pre ? (s1_post_ok_reg && time_rd.post_spiked)
                                   : (s1_pre_ok_reg && time_rd.pre_spiked);
        lookup.last    = s1_is_pre ? time_rd.post_time : time_rd.pre_time;
        lookup.now     = s1_now_reg;
    end

    weight_t win_value;

    stdp_window_mem u_window_mem (
        .clk       (clk),
        .wr        (win_wr),
        .lk        (lookup),
        .win_value (win_value)
    );

    // ------------------------------------------------------------------
    // stage 2: add and clip into the result queue
    // ------------------------------------------------------------------
    logic                s2_valid_reg;
    logic                s2_pre_reg;
    weight_t             s2_weight_reg;
    logic [NEURON_W-1:0] s2_post_reg;
    weight_t             new_weight;
    result_t             result;
    result_t             head;
    logic [FIFO_CW-1:0]  fifo_count;
    logic [FIFO_CW:0]    committed;
    logic                pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= lookup.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup.valid)
        begin
            s2_pre_reg    <= s1_is_pre;
            s2_weight_reg <= s1_weight_reg;
            s2_post_reg   <= s1_post_reg;
        end
    end

    stdp_weight_clip u_weight_clip (
        .enable     (enable_reg),
        .depress    (s2_pre_reg),
        .weight_in  (s2_weight_reg),
        .win_value  (win_value),
        .min_weight (min_weight_reg),
        .max_weight (max_weight_reg),
        .weight_out (new_weight)
    );

    always_comb
    begin
        result.weight   = new_weight;
        result.target   = s2_pre_reg ? s2_post_reg : '0;
        result.transmit = s2_pre_reg;
    end

    assign pop = out_valid && !out_stall;

    stdp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (result),
        .pop       (pop),
        .head      (head),
        .count     (fifo_count)
    );

    // every result word in flight already holds a queue slot
    assign committed = {1'b0, fifo_count} + (FIFO_CW + 1)'(lookup.valid)
                     + (FIFO_CW + 1)'(s2_valid_reg);
    assign in_stall  = clr_busy || (committed >= (FIFO_CW + 1)'(FIFO_DEPTH));

    assign out_valid     = fifo_count != '0;
    assign weight_out    = head.weight;
    assign target_neuron = head.target;
    assign transmit      = head.transmit;

endmodule

/* src/stdp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdp_checker: port checks for the STDP update block
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module stdp_checker
    import stdp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic [1:0]          action,
    input logic                out_valid,
    input logic                out_stall,
    input weight_t             weight_out,
    input logic [NEURON_W-1:0] target_neuron,
    input logic                transmit
);

    // held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(weight_out)
                                  && $stable(target_neuron) && $stable(transmit))
        else $error("result word changed while stalled");

    // clear sweep blocks input right after reset
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> in_stall)
        else $error("input taken during clear sweep");

    // accepted synapse words are followed by out_valid after the time read, window read and queue write
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && ((action == ACT_PRE) || (action == ACT_POST))
        |-> ##3 out_valid)
        else $error("synapse result missing");

    // post-event results carry no target
    a_post_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !transmit |-> target_neuron == '0)
        else $error("post result with non-zero target");

endmodule

bind pair_stdp_weight_update stdp_checker u_stdp_checker (.*);
